/* design/led_brightness_ramp_animator_top_macros.svh */
// assertion macros for the led brightness ramp animator
// expects clk and rst_n in scope at the point of use
`ifndef LED_BRIGHTNESS_RAMP_ANIMATOR_TOP_MACROS_SVH
`define LED_BRIGHTNESS_RAMP_ANIMATOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define LBRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LBRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lbra_pkg.sv */
// shared types and constants for the led brightness ramp animator
// no dependencies
package lbra_pkg;

    // input item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_BLINK = 2'd1;
    localparam logic [1:0] KIND_FIXED = 2'd2;

    // default fixed-ramp period in ms
    localparam int FIXED_PERIOD_MS_DEF = 500;

    // shortest allowed period
    localparam logic [15:0] MIN_PERIOD = 16'd2;

    // restoring divider: 24-bit dividend, one quotient bit per cycle
    localparam int DIV_STEPS = 24;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_BLINK = 2'd1,
        MODE_FIXED = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        OP_NONE        = 3'd0,
        OP_START_BLINK = 3'd1,
        OP_START_FIXED = 3'd2,
        OP_RESTART     = 3'd3,
        OP_STOP        = 3'd4,
        OP_DIV_INIT    = 3'd5,
        OP_DIV_STEP    = 3'd6
    } op_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic [7:0]  hue_in;
        logic [15:0] period_in;
        logic        loop_in;
    } item_t;

    typedef struct packed {
        logic [7:0] led_hue;
        logic [7:0] led_value;
        logic       finished;
    } result_t;

    // controller to datapath
    typedef struct packed {
        op_t  op;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_blink;
        logic start_fixed;
        logic tick_live;
        logic expired;
        logic looping;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

/* design/led_brightness_ramp_animator_top.sv */
// top level of the led brightness ramp animator
// depends on lbra_pkg, lbra_ctrl and lbra_datapath
//
// usage
//   item channel (item_valid / item_stall / item): start commands and ms ticks.
//   kind blink stores hue, period (at least 2) and loop flag; kind fixed stores
//   hue, FIXED_PERIOD_MS and looping on. start commands give no result.
//   result channel (result_valid / result_stall / result): hue and brightness
//   for a tick inside the period, or a dark result with finished set when a
//   one-shot animation ends. a looping period end restarts with no result.
//   start commands, idle ticks and restarts finish on accept; a tick inside the
//   period runs accept, 24 steps of the serial restoring divider and a result
//   load; a one-shot end runs accept and a result load. result_valid comes from
//   the output register after the load; item_stall is high until idle again.
//   the result sits in an output register, so the next item is taken while a
//   result waits; if the receiver stalls, the next result holds the block in
//   its output state until the register frees.
//   reset clears the animation state to no animation and empties the output.
module led_brightness_ramp_animator_top
    import lbra_pkg::*;
#(
    parameter int FIXED_PERIOD_MS = FIXED_PERIOD_MS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    cmd_t    cmd;
    status_t sts;

    // sequencer
    lbra_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // state, divider and result register
    lbra_datapath #(
        .FIXED_PERIOD_MS (FIXED_PERIOD_MS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* design/lbra_datapath.sv */
// datapath: animation state, elapsed-time compare, serial divider, result register
// depends on lbra_pkg
module lbra_datapath
    import lbra_pkg::*;
#(
    parameter int FIXED_PERIOD_MS = FIXED_PERIOD_MS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  cmd_t    cmd,
    output status_t sts,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam logic [15:0] FIXED_PER = (FIXED_PERIOD_MS < 2) ? MIN_PERIOD
                                                              : 16'(FIXED_PERIOD_MS);

    mode_t       mode_reg;
    logic [7:0]  hue_reg;
    logic [15:0] period_reg;
    logic        looping_reg;
    logic [31:0] start_reg;

    logic        dark_reg;
    logic        falling_reg;
    logic [14:0] rem_reg;
    logic [23:0] dvd_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic    out_valid_reg;
    result_t result_reg;

    logic [31:0] elapsed;
    logic [15:0] el16;
    logic [14:0] half;
    logic        rising;
    logic [15:0] base;
    logic [23:0] numer;
    logic [15:0] trial;
    logic        qbit;
    logic [14:0] rem_next;
    logic [8:0]  quo;
    logic [7:0]  value;

    // elapsed time and numerator for the scale to 255
    always_comb
    begin
        elapsed = item.now_ms - start_reg;
        el16    = elapsed[15:0];
        half    = period_reg[15:1];
        rising  = el16 < {1'b0, half};
        base    = (mode_reg == MODE_BLINK && !rising) ? el16 - {1'b0, half} : el16;
        numer   = {base, 8'd0} - {8'd0, base};
    end

    // one restoring divide step
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[23]};
        qbit     = trial >= {1'b0, half};
        rem_next = qbit ? 15'(trial - {1'b0, half}) : trial[14:0];
    end

    // brightness from the quotient
    always_comb
    begin
        quo = dvd_reg[8:0];
        if (falling_reg)
            value = (quo >= 9'd255) ? 8'd0 : 8'd255 - quo[7:0];
        else
            value = quo[7:0];
    end

    // status for the controller
    always_comb
    begin
        sts.start_blink = item.kind == KIND_BLINK;
        sts.start_fixed = item.kind == KIND_FIXED;
        sts.tick_live   = item.kind == KIND_TICK && mode_reg != MODE_NONE;
        sts.expired     = elapsed >= {16'd0, period_reg};
        sts.looping     = looping_reg;
        sts.div_done    = cnt_reg == CNT_W'(DIV_STEPS - 1);
        sts.out_free    = !out_valid_reg || !result_stall;
    end

    // animation state and divider control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NONE;
            hue_reg     <= 8'd0;
            period_reg  <= 16'd0;
            looping_reg <= 1'b0;
            start_reg   <= 32'd0;
            cnt_reg     <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_START_BLINK:
                begin
                    mode_reg    <= MODE_BLINK;
                    hue_reg     <= item.hue_in;
                    period_reg  <= (item.period_in < MIN_PERIOD) ? MIN_PERIOD
                                                                 : item.period_in;
                    looping_reg <= item.loop_in;
                    start_reg   <= item.now_ms;
                end
                OP_START_FIXED:
                begin
                    mode_reg    <= MODE_FIXED;
                    hue_reg     <= item.hue_in;
                    period_reg  <= FIXED_PER;
                    looping_reg <= 1'b1;
                    start_reg   <= item.now_ms;
                end
                OP_RESTART:
                    start_reg <= item.now_ms;
                OP_STOP:
                begin
                    mode_reg <= MODE_NONE;
                    hue_reg  <= 8'd0;
                end
                OP_DIV_INIT:
                    cnt_reg <= '0;
                OP_DIV_STEP:
                    cnt_reg <= cnt_reg + CNT_W'(1);
                default:
                    ;
            endcase
        end
    end

    // divider operands and pending-result kind
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_STOP:
                dark_reg <= 1'b1;
            OP_DIV_INIT:
            begin
                dark_reg    <= 1'b0;
                falling_reg <= mode_reg == MODE_BLINK && !rising;
                rem_reg     <= 15'd0;
                dvd_reg     <= numer;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[22:0], qbit};
            end
            default:
                ;
        endcase
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (dark_reg)
            begin
                result_reg.led_hue   <= 8'd0;
                result_reg.led_value <= 8'd0;
                result_reg.finished  <= 1'b1;
            end
            else
            begin
                result_reg.led_hue   <= hue_reg;
                result_reg.led_value <= value;
                result_reg.finished  <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

/* design/lbra_ctrl.sv */
// controller: decodes accepted items and sequences the divider and result transfer
// depends on lbra_pkg and the assertion macro header
`include "led_brightness_ramp_animator_top_macros.svh"

module lbra_ctrl
    import lbra_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  status_t sts,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   div_start;

    assign item_stall = state_reg != S_IDLE;
    assign accept     = item_valid && state_reg == S_IDLE;

    // accepted live tick inside the period
    assign div_start = accept && !sts.start_blink && !sts.start_fixed && sts.tick_live
                       && !sts.expired;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sts.start_blink)
                        cmd.op = OP_START_BLINK;
                    else if (sts.start_fixed)
                        cmd.op = OP_START_FIXED;
                    else if (sts.tick_live)
                    begin
                        if (!sts.expired)
                        begin
                            cmd.op     = OP_DIV_INIT;
                            state_next = S_DIV;
                        end
                        else if (sts.looping)
                            cmd.op = OP_RESTART;
                        else
                        begin
                            cmd.op     = OP_STOP;
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (sts.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // results are loaded only after a divide or a stop
    `LBRA_ASSERT_NOW(a_load_in_out, cmd.out_load, state_reg == S_OUT, "load outside output state")
    // a live tick inside the period starts the divider
    `LBRA_ASSERT_NEXT(a_tick_divides, div_start, state_reg == S_DIV, "tick did not start divide")
    // a one-shot ending goes straight to the result transfer
    `LBRA_ASSERT_NEXT(a_stop_outputs, cmd.op == OP_STOP, state_reg == S_OUT, "no output after stop")
    // divider steps run only while busy
    `LBRA_ASSERT_NOW(a_step_busy, cmd.op == OP_DIV_STEP, item_stall, "divide step while idle")

endmodule
